// ===== sv/wfg_pkg.sv =====
// Package for the window function generator: formats, coefficients, shared types
// and the quarter-wave cosine pair table built at elaboration.
// No dependencies.
`default_nettype none

package wfg_pkg;

  localparam int COS_TABLE_DEPTH = 1024;
  localparam int FRAC_BITS       = 16;

  localparam int POS_W    = FRAC_BITS + 2;             // signed position, Q2.F
  localparam int WEIGHT_W = FRAC_BITS + 1;             // unsigned weight, Q1.F
  localparam int QTR_W    = FRAC_BITS - 2;             // bits inside one quadrant
  localparam int U_W      = FRAC_BITS - 1;             // quadrant offset, 0..quarter
  localparam int IDX_W    = $clog2(COS_TABLE_DEPTH + 1);
  localparam int SCL_W    = U_W + IDX_W;               // offset scaled by table depth
  localparam int COS_W    = FRAC_BITS + 1;             // table entry, 0..one
  localparam int PAIR_W   = 2 * COS_W;
  localparam int CPROD_W  = COS_W + U_W;               // interpolation product
  localparam int MPROD_W  = 2 * FRAC_BITS + 3;         // coefficient times cosine
  localparam int ACC_W    = 2 * FRAC_BITS + 4;

  localparam longint unsigned ONE_VAL = 64'd1 << FRAC_BITS;
  localparam longint unsigned QTR_VAL = 64'd1 << QTR_W;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;

  // Taylor term divisors (2n+1)*(2n+2) for n = 0..11
  localparam longint unsigned TAYLOR_DIV [12] = '{
    64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
    64'd182, 64'd240, 64'd306, 64'd380, 64'd462, 64'd552
  };

  // Window coefficients, rounded to nearest in Q.F
  localparam logic [FRAC_BITS-1:0] COEF_HAM_A =
    FRAC_BITS'((64'd53836 * ONE_VAL + 64'd50000) / 64'd100000);
  localparam logic [FRAC_BITS-1:0] COEF_HAM_B =
    FRAC_BITS'((64'd46164 * ONE_VAL + 64'd50000) / 64'd100000);
  localparam logic [FRAC_BITS-1:0] COEF_HALF =
    FRAC_BITS'((64'd50000 * ONE_VAL + 64'd50000) / 64'd100000);
  localparam logic [FRAC_BITS-1:0] COEF_BLK_A =
    FRAC_BITS'((64'd42000 * ONE_VAL + 64'd50000) / 64'd100000);
  localparam logic [FRAC_BITS-1:0] COEF_BLK_C =
    FRAC_BITS'((64'd8000 * ONE_VAL + 64'd50000) / 64'd100000);

  typedef enum logic [1:0] {
    WK_RECT     = 2'd0,
    WK_HAMMING  = 2'd1,
    WK_HANN     = 2'd2,
    WK_BLACKMAN = 2'd3
  } kind_t;

  typedef struct packed {
    logic  valid;
    logic  outside;
    kind_t kind;
  } ctl_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [QTR_W-1:0] frac;
    logic             neg;
  } phase_t;

  // Entry k holds {t[k+1], t[k]}; the last entry repeats t[DEPTH]
  typedef logic [PAIR_W-1:0] pair_rom_t [0:COS_TABLE_DEPTH];

  // cos(pi/2 * k / DEPTH) by an integer Taylor series in Q30, rounded to Q.F
  function automatic pair_rom_t build_pair_rom();
    logic [COS_W-1:0]  tab [0:COS_TABLE_DEPTH];
    pair_rom_t         rom;
    longint unsigned   theta;
    longint unsigned   th2;
    longint unsigned   term;
    longint            acc;
    int                k;
    int                n;
    for (k = 0; k <= COS_TABLE_DEPTH; k++) begin
      theta = (PI_HALF_Q30 * 64'(k)) / 64'(COS_TABLE_DEPTH);
      th2   = (theta * theta) >> 30;
      term  = 64'd1 << 30;
      acc   = 64'sd1 << 30;
      for (n = 0; n < 12; n++) begin
        term = (term * th2) >> 30;
        term = term / TAYLOR_DIV[n];
        if (n % 2 == 1) begin
          acc = acc + longint'(term);
        end else begin
          acc = acc - longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > (64'sd1 << 30)) begin
        acc = 64'sd1 << 30;
      end
      tab[k] = COS_W'((longint'(acc) + (64'sd1 << (29 - FRAC_BITS))) >>> (30 - FRAC_BITS));
    end
    for (k = 0; k < COS_TABLE_DEPTH; k++) begin
      rom[k] = {tab[k+1], tab[k]};
    end
    rom[COS_TABLE_DEPTH] = {tab[COS_TABLE_DEPTH], tab[COS_TABLE_DEPTH]};
    return rom;
  endfunction

endpackage

`default_nettype wire

// ===== sv/wfg_phase.sv =====
// Front stage of the window pipeline: window range check and phase-to-table
// address for cos(2*pi*x) and cos(4*pi*x). Depends on wfg_pkg.
`default_nettype none

module wfg_phase
  import wfg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    accept,
  input  wire logic signed [POS_W-1:0] position,
  input  wire kind_t                   kind,
  output ctl_t                         ctl_r,
  output phase_t                       ph1_r,
  output phase_t                       ph2_r
);

  ctl_t   ctl_nxt;
  phase_t ph1_nxt;
  phase_t ph2_nxt;

  // Fold one turn into a quadrant offset, scale by table depth, split index/fraction
  function automatic phase_t to_phase(logic [FRAC_BITS-1:0] ph);
    logic [1:0]       quad;
    logic [U_W-1:0]   u;
    logic [SCL_W-1:0] scaled;
    phase_t           res;
    quad   = ph[FRAC_BITS-1 -: 2];
    u      = quad[0] ? (U_W'(QTR_VAL) - {1'b0, ph[QTR_W-1:0]}) : {1'b0, ph[QTR_W-1:0]};
    scaled = SCL_W'(u) * SCL_W'(COS_TABLE_DEPTH);
    res.idx  = scaled[QTR_W +: IDX_W];
    res.frac = scaled[QTR_W-1:0];
    res.neg  = quad[1] ^ quad[0];
    return res;
  endfunction

  always_comb begin
    ctl_nxt.valid   = accept;
    ctl_nxt.outside = position[POS_W-1] ||
                      (position[POS_W-2:0] > (POS_W-1)'(ONE_VAL));
    ctl_nxt.kind    = kind;
    ph1_nxt         = to_phase(position[FRAC_BITS-1:0]);
    ph2_nxt         = to_phase({position[FRAC_BITS-2:0], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ph1_r <= ph1_nxt;
    ph2_r <= ph2_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/wfg_cos_rom.sv =====
// Quarter-wave cosine ROM holding neighboring entry pairs, registered read.
// Depends on wfg_pkg.
`default_nettype none

module wfg_cos_rom
  import wfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  addr,
  output logic      [PAIR_W-1:0] rd_data_r
);

  localparam pair_rom_t ROM = build_pair_rom();

  always_ff @(posedge clk) begin
    rd_data_r <= ROM[addr];
  end

endmodule

`default_nettype wire

// ===== sv/wfg_cos_unit.sv =====
// Cosine unit: table read, interpolation products, rounding and sign.
// Three register stages. Depends on wfg_pkg and wfg_cos_rom.
`default_nettype none

module wfg_cos_unit
  import wfg_pkg::*;
(
  input  wire logic               clk,
  input  wire phase_t             phase,
  output logic signed [COS_W:0]   cos_r
);

  logic [PAIR_W-1:0]  pair;
  logic [QTR_W-1:0]   frac2_r;
  logic               neg2_r;
  logic               neg3_r;
  logic [CPROD_W-1:0] prod_lo_r;
  logic [CPROD_W-1:0] prod_hi_r;
  logic [U_W-1:0]     wlo;
  logic [CPROD_W-1:0] sum;
  logic [COS_W-1:0]   mag;
  logic signed [COS_W:0] mag_s;

  wfg_cos_rom u_rom (
    .clk       (clk),
    .addr      (phase.idx),
    .rd_data_r (pair)
  );

  assign wlo   = U_W'(QTR_VAL) - {1'b0, frac2_r};
  assign sum   = prod_lo_r + prod_hi_r + CPROD_W'(QTR_VAL >> 1);
  assign mag   = COS_W'(sum >> QTR_W);
  assign mag_s = $signed({1'b0, mag});

  always_ff @(posedge clk) begin
    frac2_r   <= phase.frac;
    neg2_r    <= phase.neg;
    prod_lo_r <= CPROD_W'(pair[COS_W-1:0]) * CPROD_W'(wlo);
    prod_hi_r <= CPROD_W'(pair[PAIR_W-1:COS_W]) * CPROD_W'(frac2_r);
    neg3_r    <= neg2_r;
    cos_r     <= neg3_r ? -mag_s : mag_s;
  end

endmodule

`default_nettype wire

// ===== sv/wfg_combine.sv =====
// Back end of the window pipeline: coefficient products, sum, clamp, rounding
// and saturation into the result register. Depends on wfg_pkg.
`default_nettype none

module wfg_combine
  import wfg_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire ctl_t                  ctl,
  input  wire logic signed [COS_W:0] c1,
  input  wire logic signed [COS_W:0] c2,
  output logic                       valid_r,
  output logic [WEIGHT_W-1:0]        weight_r
);

  ctl_t                        ctl5_r;
  logic [FRAC_BITS-1:0]        coef_b;
  logic [FRAC_BITS-1:0]        coef_c;
  logic [FRAC_BITS-1:0]        base;
  logic signed [MPROD_W-1:0]   prod_b_r;
  logic signed [MPROD_W-1:0]   prod_c_r;
  logic signed [ACC_W-1:0]     base_s;
  logic signed [ACC_W-1:0]     acc;
  logic [ACC_W-1:0]            rnd;
  logic [ACC_W-FRAC_BITS-1:0]  w_full;
  logic [WEIGHT_W-1:0]         weight_nxt;

  always_comb begin
    unique case (ctl.kind)
      WK_HAMMING: begin
        coef_b = COEF_HAM_B;
        coef_c = '0;
      end
      WK_HANN: begin
        coef_b = COEF_HALF;
        coef_c = '0;
      end
      WK_BLACKMAN: begin
        coef_b = COEF_HALF;
        coef_c = COEF_BLK_C;
      end
      default: begin
        coef_b = '0;
        coef_c = '0;
      end
    endcase
  end

  always_comb begin
    unique case (ctl5_r.kind)
      WK_HAMMING:  base = COEF_HAM_A;
      WK_HANN:     base = COEF_HALF;
      WK_BLACKMAN: base = COEF_BLK_A;
      default:     base = '0;
    endcase
    base_s = $signed(ACC_W'(base) << FRAC_BITS);
    acc    = base_s - ACC_W'(prod_b_r) + ACC_W'(prod_c_r);
    rnd    = $unsigned(acc) + ACC_W'(ONE_VAL >> 1);
    w_full = rnd[ACC_W-1:FRAC_BITS];
    priority if (ctl5_r.outside) begin
      weight_nxt = '0;
    end else if (ctl5_r.kind == WK_RECT) begin
      weight_nxt = WEIGHT_W'(ONE_VAL);
    end else if (acc[ACC_W-1]) begin
      weight_nxt = '0;
    end else if (w_full > (ACC_W-FRAC_BITS)'(ONE_VAL)) begin
      weight_nxt = WEIGHT_W'(ONE_VAL);
    end else begin
      weight_nxt = WEIGHT_W'(w_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl5_r  <= '0;
      valid_r <= 1'b0;
    end else begin
      ctl5_r  <= ctl;
      valid_r <= ctl5_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_b_r <= MPROD_W'($signed({1'b0, coef_b})) * MPROD_W'(c1);
    prod_c_r <= MPROD_W'($signed({1'b0, coef_c})) * MPROD_W'(c2);
    weight_r <= weight_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/window_function_generator_unit.sv =====
// Top level of the window function generator: configuration register, pipeline
// control and the front, cosine and combine stages. Depends on wfg_pkg and
// wfg_phase, wfg_cos_unit, wfg_combine.
//
// Usage:
//   Input channel: drive in_sample_position (signed Q2.16 position x) and raise
//   start; a word is taken at every rising edge with start high and busy low.
//   busy is high during reset and until the first clock edge with rst_n high;
//   from then on one position can enter in every cycle.
//   Result channel: out_weight (unsigned Q1.16, 65536 is 1.0) shows for exactly
//   one cycle with out_valid high. The receiver cannot stall; results simply
//   leave in input order, one per accepted word.
//   Pipeline: a taken word passes six register stages (phase, table read,
//   interpolation products, cosine, coefficient products, result) before
//   out_valid rises with its result. Throughput: one word per cycle.
//   Configuration: register window_kind at byte address 0 over the APB port
//   (0 rectangle, 1 Hamming, 2 Hann, 3 Blackman); write it only while no word
//   is in flight. pready is always high; reads return the register.
//   Positions below 0 or above 1.0 give weight 0 for every window.
//   Reset (synchronous, rst_n low): drop all words in flight, return
//   window_kind to rectangle, hold busy high.
`default_nettype none

module window_function_generator_unit
  import wfg_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  // input channel
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic signed [POS_W-1:0] in_sample_position,
  // result channel
  output logic                         out_valid,
  output logic [WEIGHT_W-1:0]          out_weight,
  // configuration port
  input  wire logic                    psel,
  input  wire logic                    penable,
  input  wire logic                    pwrite,
  input  wire logic [1:0]              paddr,
  input  wire logic [31:0]             pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  localparam logic [1:0] ADDR_WINDOW_KIND = 2'd0;

  logic   busy_r;
  kind_t  kind_r;
  logic   cfg_write;
  ctl_t   ctl1;
  ctl_t   ctl2_r;
  ctl_t   ctl3_r;
  ctl_t   ctl4_r;
  phase_t ph1;
  phase_t ph2;
  logic signed [COS_W:0] cos1;
  logic signed [COS_W:0] cos2;

  // Register write completes in the access phase; pready never drops
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_WINDOW_KIND);
  assign prdata    = (paddr == ADDR_WINDOW_KIND) ? {30'd0, kind_r} : '0;
  assign busy      = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      kind_r <= WK_RECT;
    end else begin
      busy_r <= 1'b0;
      if (cfg_write) begin
        kind_r <= kind_t'(pwdata[1:0]);
      end
    end
  end

  // Stage 1: range check and table addresses
  wfg_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (start && !busy_r),
    .position (in_sample_position),
    .kind     (kind_r),
    .ctl_r    (ctl1),
    .ph1_r    (ph1),
    .ph2_r    (ph2)
  );

  // Stages 2-4: cos(2*pi*x) and cos(4*pi*x) side by side
  wfg_cos_unit u_cos1 (
    .clk   (clk),
    .phase (ph1),
    .cos_r (cos1)
  );

  wfg_cos_unit u_cos2 (
    .clk   (clk),
    .phase (ph2),
    .cos_r (cos2)
  );

  // Advance the control word alongside the cosine stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r <= '0;
      ctl3_r <= '0;
      ctl4_r <= '0;
    end else begin
      ctl2_r <= ctl1;
      ctl3_r <= ctl2_r;
      ctl4_r <= ctl3_r;
    end
  end

  // Stages 5-6: weighted sum, clamp, round, saturate
  wfg_combine u_combine (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl4_r),
    .c1       (cos1),
    .c2       (cos2),
    .valid_r  (out_valid),
    .weight_r (out_weight)
  );

endmodule

`default_nettype wire

// ===== sv/wfg_checker.sv =====
// Port-level checker for the window function generator, bound to the top level.
// Depends on wfg_pkg.
`default_nettype none

module wfg_checker
  import wfg_pkg::*;
(
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire logic [POS_W-1:0]    in_sample_position,
  input wire logic                out_valid,
  input wire logic [WEIGHT_W-1:0] out_weight
);

  // Every result traces back to a word taken one pipeline depth earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 6))
    else $error("result without a word taken six cycles earlier");

  // Negative positions lie outside the window
  a_outside: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(start && !busy && in_sample_position[POS_W-1], 6)
      |-> out_weight == '0)
    else $error("nonzero weight for a negative position");

  // Weight never exceeds 1.0
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_weight[WEIGHT_W-1] || out_weight[WEIGHT_W-2:0] == '0))
    else $error("weight above 1.0");

  // Out of reset the block always takes words
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !busy)
    else $error("busy raised outside reset");

endmodule

bind window_function_generator_unit wfg_checker u_wfg_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .in_sample_position (in_sample_position),
  .out_valid          (out_valid),
  .out_weight         (out_weight)
);

`default_nettype wire
